// ===== hdl/pvd_pkg.sv =====
// Shared types and constants for the posting varint decoder.
// Depends on nothing; every other file of the block refers to it by scoped names.

package pvd_pkg;

  // A varint byte adds 7 payload bits, so only the first five bytes reach a 32-bit value.
  localparam int unsigned AccBytes = 5;

  typedef enum logic [1:0] {
    PH_DOC    = 2'd0,
    PH_SIZE   = 2'd1,
    PH_LIST   = 2'd2,
    PH_RESYNC = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DOC = 2'd0,
    KIND_POS = 2'd1,
    KIND_BAD = 2'd2
  } kind_e;

  // Register index of the configuration port.
  localparam logic [1:0] RegPosEnable = 2'd0;

  // Posting state kept between bytes (the varint byte count is kept apart,
  // its width follows the top-level parameter).
  typedef struct packed {
    phase_e      phase;
    logic [31:0] acc;
    logic [15:0] left;
    logic [31:0] held;
    logic [31:0] prev;
    logic [15:0] pcount;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [15:0] pos_idx;
    logic        last;
  } result_t;

endpackage

// ===== hdl/pvd_apb_regs.sv =====
// APB-style configuration register for the posting varint decoder.
// Depends on pvd_pkg for the register index.

module pvd_apb_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        pos_enable_o
);

  logic incl_q, incl_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready
                  && (paddr == pvd_pkg::RegPosEnable);

  always_comb begin
    incl_d = incl_q;
    if (wr_en) begin
      incl_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incl_q <= 1'b1;
    end else begin
      incl_q <= incl_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == pvd_pkg::RegPosEnable) begin
      prdata = {31'd0, incl_q};
    end
  end

  assign pos_enable_o = incl_q;

endmodule

// ===== hdl/pvd_step.sv =====
// One-byte update of the posting decoder: next state and optional result.
// Depends on pvd_pkg for the state, result, phase and kind types.

module pvd_step #(
  parameter int unsigned MaxBytes = 5,
  parameter int unsigned CntW     = 3
) (
  input  pvd_pkg::state_t  state_i,
  input  logic [CntW-1:0]  cnt_i,
  input  logic [7:0]       byte_i,
  input  logic             record_start_i,
  input  logic             incl_i,
  output pvd_pkg::state_t  state_o,
  output logic [CntW-1:0]  cnt_o,
  output logic             res_valid_o,
  output pvd_pkg::result_t res_o
);

  pvd_pkg::phase_e  ph;
  logic [31:0]      acc_in;
  logic [CntW-1:0]  cnt_in;
  logic [4:0]       shamt;
  logic [31:0]      acc_new;
  logic [CntW-1:0]  cnt_new;
  logic             more;
  logic             too_long;
  logic [15:0]      left_dec;
  logic [31:0]      pos_sum;

  // A forced record start drops any partial varint.
  always_comb begin
    ph     = record_start_i ? pvd_pkg::PH_DOC : state_i.phase;
    acc_in = record_start_i ? '0 : state_i.acc;
    cnt_in = record_start_i ? '0 : cnt_i;
  end

  // Varint byte feed: only the first five bytes land inside 32 bits.
  always_comb begin
    shamt   = 5'(cnt_in[2:0]) * 5'd7;
    acc_new = acc_in;
    if (cnt_in < CntW'(pvd_pkg::AccBytes)) begin
      acc_new = acc_in | ({25'd0, byte_i[6:0]} << shamt);
    end
    cnt_new  = cnt_in + CntW'(1);
    more     = byte_i[7];
    too_long = more && (cnt_new >= CntW'(MaxBytes));
  end

  assign left_dec = (state_i.left != '0) ? state_i.left - 16'd1 : '0;
  assign pos_sum  = state_i.prev + acc_new;

  always_comb begin
    state_o       = state_i;
    state_o.phase = ph;
    state_o.acc   = acc_in;
    cnt_o         = cnt_in;
    res_valid_o   = 1'b0;
    res_o.kind    = pvd_pkg::KIND_DOC;
    res_o.value   = state_i.held;
    res_o.pos_idx = '0;
    res_o.last    = 1'b0;

    unique case (ph)
      pvd_pkg::PH_DOC: begin
        if (more) begin
          state_o.acc = acc_new;
          cnt_o       = cnt_new;
        end else begin
          state_o.held   = {1'b0, acc_new[31:1]};
          state_o.prev   = '0;
          state_o.pcount = '0;
          state_o.acc    = '0;
          cnt_o          = '0;
          if (acc_new[0]) begin
            // Single-byte position list.
            state_o.left  = 16'd1;
            state_o.phase = pvd_pkg::PH_LIST;
            res_valid_o   = 1'b1;
            res_o.value   = {1'b0, acc_new[31:1]};
            res_o.last    = !incl_i;
          end else begin
            state_o.phase = pvd_pkg::PH_SIZE;
          end
        end
      end

      pvd_pkg::PH_SIZE: begin
        if (more) begin
          state_o.acc = acc_new;
          cnt_o       = cnt_new;
        end else begin
          state_o.left = (|acc_new[31:16]) ? 16'hFFFF : acc_new[15:0];
          state_o.acc  = '0;
          cnt_o        = '0;
          res_valid_o  = 1'b1;
          if ((acc_new == '0)) begin
            // Empty list: the document delta closes the posting.
            state_o.phase = pvd_pkg::PH_DOC;
            res_o.last    = 1'b1;
          end else begin
            state_o.phase = pvd_pkg::PH_LIST;
            res_o.last    = !incl_i;
          end
        end
      end

      pvd_pkg::PH_LIST: begin
        state_o.left = left_dec;
        if (!incl_i) begin
          state_o.acc = '0;
          cnt_o       = '0;
          if (left_dec == '0) begin
            state_o.phase = pvd_pkg::PH_DOC;
          end
        end else if (more) begin
          state_o.acc = acc_new;
          cnt_o       = cnt_new;
          // An unfinished varint at the end of the list is an overrun.
          if (left_dec == '0) begin
            res_valid_o = 1'b1;
          end
        end else begin
          state_o.prev   = pos_sum;
          state_o.pcount = state_i.pcount + 16'd1;
          state_o.acc    = '0;
          cnt_o          = '0;
          res_valid_o    = 1'b1;
          res_o.kind     = pvd_pkg::KIND_POS;
          res_o.value    = pos_sum;
          res_o.pos_idx  = state_i.pcount;
          res_o.last     = (left_dec == '0);
          if (left_dec == '0) begin
            state_o.phase = pvd_pkg::PH_DOC;
          end
        end
      end

      pvd_pkg::PH_RESYNC: begin
        state_o.acc = '0;
        cnt_o       = '0;
      end

      default: begin
        state_o.phase = pvd_pkg::PH_RESYNC;
      end
    endcase

    // Malformed record: long varint in any decoded field, or overrun in the list.
    if ((too_long && ph != pvd_pkg::PH_RESYNC && !(ph == pvd_pkg::PH_LIST && !incl_i))
        || (ph == pvd_pkg::PH_LIST && incl_i && more && left_dec == '0)) begin
      state_o.phase = pvd_pkg::PH_RESYNC;
      state_o.acc   = '0;
      cnt_o         = '0;
      res_valid_o   = 1'b1;
      res_o.kind    = pvd_pkg::KIND_BAD;
      res_o.value   = '0;
      res_o.pos_idx = '0;
      res_o.last    = 1'b1;
    end
  end

endmodule

// ===== hdl/pvd_out_buffer.sv =====
// Two-entry result buffer (output register plus skid stage) for the decoder.
// Depends on pvd_pkg for the result type.

module pvd_out_buffer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pvd_pkg::result_t data_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output pvd_pkg::result_t data_o
);

  logic             head_vld_q, head_vld_d;
  logic             skid_vld_q, skid_vld_d;
  pvd_pkg::result_t head_q, head_d;
  pvd_pkg::result_t skid_q, skid_d;
  logic             pop;

  assign pop     = head_vld_q && ready_i;
  assign room_o  = !skid_vld_q;
  assign valid_o = head_vld_q;
  assign data_o  = head_q;

  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    head_d     = head_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (pop) begin
        head_d     = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!head_vld_q || pop) begin
        head_d     = data_i;
        head_vld_d = 1'b1;
      end else begin
        skid_d     = data_i;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      head_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  // The skid stage only fills behind an occupied output register.
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> head_vld_q)
    else $error("skid entry held without an output entry");

  // No result may arrive while both entries are taken.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_vld_q)
    else $error("result pushed into a full buffer");

  // A held skid entry moves to the output as soon as the output drains.
  a_skid_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && ready_i) |=> (head_vld_q && !skid_vld_q && head_q == $past(skid_q)))
    else $error("skid entry did not advance");

endmodule

// ===== hdl/posting_varint_decoder_top.sv =====
// Top level of the posting varint decoder: input stream, config port, result stream.
// Depends on pvd_pkg, pvd_apb_regs, pvd_step and pvd_out_buffer.
//
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid/tready      tdata[7:0] data_byte, tuser[0] record_start
// m_axis    out  tvalid/tready      tdata[31:0] value, tdata[47:32] position_index,
//                                   tuser[1:0] kind, tlast last_of_posting
// apb       in   psel/penable       paddr 0: position enable (bit 0), pready tied high
//
// Each accepted byte is decoded in the cycle of its transfer: the varint step logic reads
// the posting state registers and the byte, and writes the state and at most one result.
// The result is registered in the output buffer and shown on m_axis from there; one byte
// is taken every cycle while s_axis_tready_o is high. A two-entry output buffer (output
// register plus skid) keeps the input flowing while one result waits; s_axis_tready_o
// drops only when both entries are full. Reset puts the decoder at the start of a posting
// with positions enabled and the output buffer empty; no clearing pass is needed.

module posting_varint_decoder_top #(
  parameter int unsigned MAX_VARINT_BYTES = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] record_start

  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [31:0] value, [47:32] position_index
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o,   // last_of_posting

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The byte counter must hold MAX_VARINT_BYTES itself.
  localparam int unsigned CntW = $clog2(MAX_VARINT_BYTES + 1);

  logic             incl;
  logic             in_xfer;
  pvd_pkg::state_t  state_q, state_d, step_state;
  logic [CntW-1:0]  cnt_q, cnt_d, step_cnt;
  logic             res_valid;
  pvd_pkg::result_t res;
  pvd_pkg::result_t out_res;
  logic             buf_room;

  pvd_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pos_enable_o (incl)
  );

  pvd_step #(
    .MaxBytes (MAX_VARINT_BYTES),
    .CntW     (CntW)
  ) u_step (
    .state_i        (state_q),
    .cnt_i          (cnt_q),
    .byte_i         (s_axis_tdata_i),
    .record_start_i (s_axis_tuser_i[0]),
    .incl_i         (incl),
    .state_o        (step_state),
    .cnt_o          (step_cnt),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  assign s_axis_tready_o = buf_room;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // The posting state only advances on an input transfer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    if (in_xfer) begin
      state_d = step_state;
      cnt_d   = step_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: pvd_pkg::PH_DOC, default: '0};
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  pvd_out_buffer u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_xfer && res_valid),
    .data_i  (res),
    .room_o  (buf_room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (out_res)
  );

  assign m_axis_tdata_o = {out_res.pos_idx, out_res.value};
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tlast_o = out_res.last;

endmodule

// ===== sim/posting_varint_decoder_checker.sv =====
// Result checker for the posting varint decoder: decodes every accepted input byte itself
// and compares each result transfer with the oldest decoded result still awaited.
// Depends on pvd_pkg for the phase, kind and result types.

module posting_varint_decoder_checker #(
  parameter int unsigned MaxVarintBytes = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] record_start

  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [47:0] m_axis_tdata_i,   // [31:0] value, [47:32] position_index
  input  logic [1:0]  m_axis_tuser_i,   // [1:0] kind
  input  logic        m_axis_tlast_i,   // last_of_posting

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,

  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [1:0] AddrPosEnable = 2'(4 * pvd_pkg::RegPosEnable);

  typedef enum int {
    VAR_MORE,
    VAR_DONE,
    VAR_LONG
  } varint_step_e;

  pvd_pkg::phase_e  dec_phase;
  logic [31:0]      dec_acc;
  logic [3:0]       dec_nbytes;
  logic [15:0]      dec_left;
  logic [31:0]      dec_held;
  logic [31:0]      dec_prev;
  logic [15:0]      dec_pcount;
  logic             show_positions;

  pvd_pkg::result_t decoded_results_q[$];
  int               mismatch_count = 0;
  int               result_count = 0;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(input string what);
    $display("decoder result %0d: %s", result_count, what);
    mismatch_count++;
  endtask

  function automatic void drop_partial_varint();
    dec_acc    = '0;
    dec_nbytes = '0;
  endfunction

  // Bits that land above bit 31 are lost; the byte count never passes the limit because a
  // continuation bit at the limit ends the varint as malformed.
  function automatic varint_step_e absorb_varint_byte(input logic [7:0] b);
    int unsigned shift;
    shift = 7 * dec_nbytes;
    if (shift < 32) begin
      dec_acc = dec_acc | (32'(b[6:0]) << shift);
    end
    dec_nbytes = dec_nbytes + 4'd1;
    if (!b[7]) begin
      return VAR_DONE;
    end
    if (dec_nbytes >= MaxVarintBytes) begin
      return VAR_LONG;
    end
    return VAR_MORE;
  endfunction

  function automatic void push_decoded(input pvd_pkg::kind_e kind, input logic [31:0] value,
                                       input logic [15:0] idx, input logic last);
    pvd_pkg::result_t r;
    r.kind    = kind;
    r.value   = value;
    r.pos_idx = idx;
    r.last    = last;
    decoded_results_q.push_back(r);
  endfunction

  function automatic void flag_malformed();
    drop_partial_varint();
    dec_phase = pvd_pkg::PH_RESYNC;
    push_decoded(pvd_pkg::KIND_BAD, '0, '0, 1'b1);
  endfunction

  task automatic decode_posting_byte(input logic [7:0] b, input logic record_start);
    varint_step_e step;
    logic [31:0]  pos;
    if (record_start) begin
      dec_phase = pvd_pkg::PH_DOC;
      drop_partial_varint();
    end
    case (dec_phase)
      pvd_pkg::PH_DOC: begin
        step = absorb_varint_byte(b);
        if (step == VAR_LONG) begin
          flag_malformed();
        end else if (step == VAR_DONE) begin
          dec_held   = dec_acc >> 1;
          dec_prev   = '0;
          dec_pcount = '0;
          if (dec_acc[0]) begin
            // The marker bit stands for a one-byte position list without a size varint.
            drop_partial_varint();
            dec_left  = 16'd1;
            dec_phase = pvd_pkg::PH_LIST;
            push_decoded(pvd_pkg::KIND_DOC, dec_held, '0, !show_positions);
          end else begin
            drop_partial_varint();
            dec_phase = pvd_pkg::PH_SIZE;
          end
        end
      end
      pvd_pkg::PH_SIZE: begin
        step = absorb_varint_byte(b);
        if (step == VAR_LONG) begin
          flag_malformed();
        end else if (step == VAR_DONE) begin
          dec_left = (dec_acc > 32'h0000_FFFF) ? 16'hFFFF : dec_acc[15:0];
          drop_partial_varint();
          if (dec_left == 0) begin
            dec_phase = pvd_pkg::PH_DOC;
            push_decoded(pvd_pkg::KIND_DOC, dec_held, '0, 1'b1);
          end else begin
            dec_phase = pvd_pkg::PH_LIST;
            push_decoded(pvd_pkg::KIND_DOC, dec_held, '0, !show_positions);
          end
        end
      end
      pvd_pkg::PH_LIST: begin
        if (dec_left != 0) begin
          dec_left = dec_left - 16'd1;
        end
        if (!show_positions) begin
          drop_partial_varint();
          if (dec_left == 0) begin
            dec_phase = pvd_pkg::PH_DOC;
          end
        end else begin
          step = absorb_varint_byte(b);
          if (step == VAR_LONG) begin
            flag_malformed();
          end else if (step == VAR_MORE) begin
            if (dec_left == 0) begin
              flag_malformed();
            end
          end else begin
            pos = dec_prev + dec_acc;
            push_decoded(pvd_pkg::KIND_POS, pos, dec_pcount, dec_left == 0);
            dec_prev   = pos;
            dec_pcount = dec_pcount + 16'd1;
            drop_partial_varint();
            if (dec_left == 0) begin
              dec_phase = pvd_pkg::PH_DOC;
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result();
    pvd_pkg::result_t want;
    if (decoded_results_q.size() == 0) begin
      report_mismatch($sformatf("kind %0d value %h arrived with nothing awaited",
                                m_axis_tuser_i, m_axis_tdata_i[31:0]));
    end else begin
      want = decoded_results_q.pop_front();
      if (m_axis_tuser_i !== want.kind) begin
        report_mismatch($sformatf("kind %0d, wanted %0d", m_axis_tuser_i, want.kind));
      end
      if (m_axis_tdata_i[31:0] !== want.value) begin
        report_mismatch($sformatf("value %h, wanted %h", m_axis_tdata_i[31:0], want.value));
      end
      if (m_axis_tdata_i[47:32] !== want.pos_idx) begin
        report_mismatch($sformatf("position index %0d, wanted %0d",
                                  m_axis_tdata_i[47:32], want.pos_idx));
      end
      if (m_axis_tlast_i !== want.last) begin
        report_mismatch($sformatf("last mark %b, wanted %b", m_axis_tlast_i, want.last));
      end
    end
    result_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_phase      = pvd_pkg::PH_DOC;
      dec_left       = '0;
      dec_held       = '0;
      dec_prev       = '0;
      dec_pcount     = '0;
      show_positions = 1'b1;
      drop_partial_varint();
      decoded_results_q.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_result();
      end
      // A byte taken at the same edge as a register write still sees the old setting.
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        decode_posting_byte(s_axis_tdata_i, s_axis_tuser_i[0]);
      end
      if (psel && penable && pwrite && pready && paddr == AddrPosEnable) begin
        show_positions = pwdata[0];
      end
      pending_o <= decoded_results_q.size();
    end
  end

endmodule

// ===== sim/posting_varint_decoder_top_test.sv =====
// Testbench top for the posting varint decoder: clock, reset, byte stream stimulus,
// result back-pressure, register writes and the verdict.
// Depends on pvd_pkg, posting_varint_decoder_top and posting_varint_decoder_checker.

module posting_varint_decoder_top_test;

  localparam int unsigned MaxVarintBytes = 5;
  localparam logic [1:0]  AddrPosEnable = 2'(4 * pvd_pkg::RegPosEnable);

  // The slowest correct run is bounded by the sender gaps plus the result stalls behind the
  // two-entry output buffer for some 1650 bytes; the limit leaves a wide margin on top of that.
  localparam int unsigned RunLimit = 400000;

  // Bytes for each random phase; together with the directed postings this gives
  // about 1650 bytes in all.
  localparam int unsigned PhaseBytes = 320;

  typedef logic [7:0] byte_q_t[$];

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic [0:0]  s_user = '0;

  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [47:0] m_data;
  logic [1:0]  m_user;
  logic        m_last;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;

  // Bytes waiting to be sent, each with its record start flag.
  logic [7:0]  stream_bytes[$];
  logic        stream_starts[$];

  // Countdown of items still to go without idling, one per side.
  int          send_calm = 0;
  int          take_calm = 0;

  posting_varint_decoder_top #(
    .MAX_VARINT_BYTES(MaxVarintBytes)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  posting_varint_decoder_checker #(
    .MaxVarintBytes(MaxVarintBytes)
  ) decode_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_i(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_i(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_i (m_data),
    .m_axis_tuser_i (m_user),
    .m_axis_tlast_i (m_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a result that never comes ends the run here.
  initial begin
    while (cycle_count < RunLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("posting_varint_decoder_top_test: FAIL");
    $finish;
  end

  // Wait before the next item. Now and then a side goes through a stretch of items with
  // no idling at all, so that back-to-back transfers are covered too.
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  // Result side: a random stall before each result, then ready until a transfer happens.
  // A zero stall keeps ready high across the transfer edge without a second assignment.
  initial begin
    int stall;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = pick_wait(take_calm);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_valid);
    end
  end

  // Varint encoding of v, stretched to at least min_len bytes with zero payload groups.
  // With wide set, a five-byte varint also carries junk above bit 31 in its last byte.
  function automatic byte_q_t varint_bytes(input logic [31:0] v, input int min_len,
                                           input bit wide);
    byte_q_t     q;
    int          len;
    int          i;
    logic [31:0] rest;
    logic [7:0]  b;
    len  = 1;
    rest = v >> 7;
    while (rest != 0) begin
      len++;
      rest = rest >> 7;
    end
    if (min_len > len) begin
      len = min_len;
    end
    for (i = 0; i < len; i++) begin
      b = (i < 5) ? 8'((v >> (7 * i)) & 32'h7F) : 8'h00;
      if (wide && i == 4) begin
        b[6:4] = 3'($urandom_range(0, 7));
      end
      b[7] = (i < len - 1);
      q.push_back(b);
    end
    return q;
  endfunction

  // A varint that still asks for more at the byte limit.
  function automatic byte_q_t long_varint();
    byte_q_t q;
    int      i;
    for (i = 0; i < MaxVarintBytes; i++) begin
      q.push_back(8'h80 | 8'($urandom_range(0, 127)));
    end
    return q;
  endfunction

  // Mostly minimal encodings, sometimes padded out to the full five bytes.
  function automatic int pick_pad();
    return ($urandom_range(0, 7) == 0) ? 5 : 0;
  endfunction

  // Values of every magnitude, weighted toward the short encodings real postings use.
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 127);
      1:       return $urandom_range(0, 16383);
      2:       return $urandom;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic stage(input byte_q_t b, input bit first_start);
    int i;
    for (i = 0; i < b.size(); i++) begin
      stream_bytes.push_back(b[i]);
      stream_starts.push_back(i == 0 ? first_start : 1'b0);
    end
  endtask

  // One random posting. Most are well formed with random content; the rest are noise,
  // long varints in each field, lists with a wrong declared size, and cut-off postings.
  task automatic stage_random_posting();
    byte_q_t     doc_b;
    byte_q_t     size_b;
    byte_q_t     list_b;
    byte_q_t     piece;
    int          style;
    int          spoil;
    int          npos;
    int          k;
    int          j;
    bit          lead;
    logic [31:0] delta;
    logic [31:0] declared;
    style = $urandom_range(0, 99);
    lead  = ($urandom_range(0, 9) != 0);
    delta = rand_value() >> 1;
    if (style < 10) begin
      k = $urandom_range(1, 6);
      for (j = 0; j < k; j++) begin
        piece = '{8'($urandom_range(0, 255))};
        stage(piece, 1'($urandom_range(0, 1)));
      end
      return;
    end
    if (style < 25) begin
      // Marker set: a one-byte list, which overruns if that byte asks for more.
      doc_b = varint_bytes({delta[30:0], 1'b1}, pick_pad(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 7) == 0) begin
        list_b = '{8'h80 | 8'($urandom_range(0, 127))};
      end else begin
        list_b = '{8'($urandom_range(0, 127))};
      end
      stage(doc_b, lead);
      stage(list_b, 1'b0);
      return;
    end
    doc_b = varint_bytes({delta[30:0], 1'b0}, pick_pad(), 1'($urandom_range(0, 1)));
    npos  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
    for (k = 0; k < npos; k++) begin
      piece = varint_bytes(rand_value(), pick_pad(), 1'($urandom_range(0, 1)));
      foreach (piece[j]) list_b.push_back(piece[j]);
    end
    declared = list_b.size();
    spoil = $urandom_range(0, 19);
    case (spoil)
      0: if (declared > 0) declared = declared - 1;
      1: declared = declared + $urandom_range(1, 3);
      2: declared = $urandom | 32'h0001_0000;
      3: doc_b = long_varint();
      5: begin
        piece = long_varint();
        foreach (piece[j]) list_b.push_back(piece[j]);
        declared = list_b.size();
      end
      6: begin
        if (list_b.size() > 0) begin
          k = $urandom_range(0, list_b.size() - 1);
          while (list_b.size() > k) void'(list_b.pop_back());
        end
      end
      default: begin
      end
    endcase
    if (spoil == 4) begin
      size_b = long_varint();
    end else begin
      size_b = varint_bytes(declared, pick_pad(), 1'($urandom_range(0, 1)));
    end
    stage(doc_b, lead);
    stage(size_b, 1'b0);
    stage(list_b, 1'b0);
  endtask

  // Sends every staged byte. On the edge of a transfer, valid either stays high with the
  // next byte or drops for a gap, never both; it drops for good once the stream is empty.
  task automatic drain_bytes();
    int gap;
    while (stream_bytes.size() != 0) begin
      gap = pick_wait(send_calm);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_valid <= 1'b1;
      s_data  <= stream_bytes.pop_front();
      s_user  <= stream_starts.pop_front();
      do @(posedge clk_i); while (!s_ready);
    end
    s_valid <= 1'b0;
  endtask

  // Waits until every decoded result has been taken, then waits out the extra edges so that a
  // byte that made no result also gets through the step.
  task automatic settle(input int extra);
    do @(posedge clk_i); while (pending != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  // Bits above the mode bit carry random junk that the block must ignore.
  task automatic write_reg(input logic [1:0] addr, input logic mode);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {31'($urandom_range(0, 32'h7FFF_FFFF)), mode};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    byte_q_t bq;
    logic    modes[5];
    int      p;
    modes = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(AddrPosEnable, 1'b1);

    // Directed postings, positions enabled.
    // A one-byte list holding the largest single-byte position.
    bq = '{8'h01, 8'h7F};
    stage(bq, 1'b1);
    // A five-byte document varint of all ones: bits above 31 fall off, delta 7FFFFFFF.
    bq = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00};
    stage(bq, 1'b1);
    // A three-byte list with positions 5 and 5 + 129.
    bq = '{8'h04, 8'h03, 8'h05, 8'h81, 8'h01};
    stage(bq, 1'b1);
    // An empty list, reached without a record start.
    bq = '{8'h02, 8'h00};
    stage(bq, 1'b0);
    // A document varint that is too long; the byte after it is ignored until resync.
    bq = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'hFF};
    stage(bq, 1'b1);
    // A list size of 65536 saturates; the next record start abandons the posting.
    bq = '{8'h00, 8'h80, 8'h80, 8'h04, 8'h03};
    stage(bq, 1'b1);
    // A one-byte list whose byte asks for more overruns the list.
    bq = '{8'h01, 8'h80};
    stage(bq, 1'b1);
    // A list of four bytes, switched to skipping after its first position: the rest is
    // dropped without being decoded, and no position carries the last mark.
    bq = '{8'h00, 8'h04, 8'h01};
    stage(bq, 1'b1);
    drain_bytes();
    settle(4);
    write_reg(AddrPosEnable, 1'b0);
    bq = '{8'h82, 8'h01, 8'h00};
    stage(bq, 1'b0);
    drain_bytes();
    settle(4);

    // Random phases, alternating between decoding and skipping the position lists.
    for (p = 0; p < 5; p++) begin
      write_reg(AddrPosEnable, modes[p]);
      while (stream_bytes.size() < PhaseBytes) stage_random_posting();
      drain_bytes();
      settle(4);
    end

    settle(8);
    if (fail_count == 0 && pending == 0) begin
      $display("posting_varint_decoder_top_test: PASS");
    end else begin
      $display("posting_varint_decoder_top_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pvd_pkg.sv
hdl/pvd_apb_regs.sv
hdl/pvd_step.sv
hdl/pvd_out_buffer.sv
hdl/posting_varint_decoder_top.sv
sim/posting_varint_decoder_checker.sv
sim/posting_varint_decoder_top_test.sv
